[rtl/core/ppss_pkg.sv]
// Package for the pin pair short scanner: payload and configuration types,
// phase codes, register indexes and reset values. No dependencies.
`default_nettype none

package ppss_pkg;

  localparam int PIN_BITS     = 26;
  localparam int NUM_PINS_DEF = 26;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  // Sequencer phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_GAP    = 2'd2;
  localparam logic [1:0] PH_RESCAN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PINS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_READ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_CONT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESCAN_GAP   = 3'd5;

  // Register reset values.
  localparam logic [4:0]  RST_ACTIVE_PINS  = 5'd26;
  localparam logic [15:0] RST_SETTLE_TICKS = 16'd200;
  localparam logic [3:0]  RST_CONFIRM_READ = 4'd3;
  localparam logic [15:0] RST_SAMPLE_GAP   = 16'd500;
  localparam logic        RST_RUN_CONT     = 1'b0;
  localparam logic [19:0] RST_RESCAN_GAP   = 20'd500000;

  typedef struct packed {
    logic                action;
    logic [PIN_BITS-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [PIN_BITS-1:0] drive_mask;
    logic [PIN_BITS-1:0] pulldown_mask;
    logic                report_valid;
    logic [4:0]          report_pin_a;
    logic [4:0]          report_pin_b;
    logic                scan_done;
    logic                busy_res;
    logic [9:0]          pairs_found;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  active_pins;
    logic [15:0] settle_ticks;
    logic [3:0]  confirm_count;
    logic [15:0] sample_gap_ticks;
    logic        run_continuous;
    logic [19:0] rescan_gap_ticks;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/ppss_seq.sv]
// Scan sequencer: holds the pair, direction, timing and count state and
// computes the result of each item in one pass. Depends on ppss_pkg.
`default_nettype none

module ppss_seq #(
  parameter int NUM_PINS = ppss_pkg::NUM_PINS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  ppss_pkg::in_item_t   item,
  input  ppss_pkg::cfg_t       cfg,
  output ppss_pkg::out_item_t  result
);

  localparam logic [5:0] PIN_CAP = 6'(NUM_PINS);

  logic [1:0]  phase, phase_next;
  logic [4:0]  first_index, first_next;
  logic [4:0]  second_index, second_next;
  logic        reverse, reverse_next;
  logic [19:0] wait_count, wait_next;
  logic [3:0]  samples_taken, samples_next;
  logic [3:0]  high_samples, high_next;
  logic        forward_short, forward_next;
  logic [9:0]  found_count, found_next;

  logic        rep_valid, done;
  logic [4:0]  rep_a, rep_b;

  logic [3:0]  need;
  logic [5:0]  pin_n;
  logic [4:0]  sensor;
  logic [31:0] levels_ext;
  logic        sense_high;
  logic        shorted;
  logic [5:0]  b_step, a_step;
  logic [6:0]  b_wrap, next_a, next_b;
  logic        wrap, last_pair;
  logic [4:0]  drv_idx, pd_idx;
  logic [ppss_pkg::PIN_BITS-1:0] drv_onehot, pd_onehot;
  logic        driving;

  assign need       = (cfg.confirm_count == 4'd0) ? 4'd1 : cfg.confirm_count;
  assign pin_n      = ({1'b0, cfg.active_pins} > PIN_CAP) ? PIN_CAP
                                                           : {1'b0, cfg.active_pins};
  assign sensor     = reverse ? first_index : second_index;
  assign levels_ext = {{(32 - ppss_pkg::PIN_BITS){1'b0}}, item.pin_levels};
  assign sense_high = levels_ext[sensor];
  assign shorted    = (high_samples == need);

  // Next pair: bump the higher index, or on wrap advance the lower index and restart the higher one just above it.
  assign b_step    = {1'b0, second_index} + 6'd1;
  assign wrap      = (b_step >= pin_n);
  assign a_step    = {1'b0, first_index} + 6'd1;
  assign b_wrap    = {1'b0, a_step} + 7'd1;
  assign next_a    = wrap ? {1'b0, a_step} : {2'b00, first_index};
  assign next_b    = wrap ? b_wrap : {1'b0, b_step};
  assign last_pair = (next_b >= {1'b0, pin_n});

  always_comb begin
    phase_next   = phase;
    first_next   = first_index;
    second_next  = second_index;
    reverse_next = reverse;
    wait_next    = wait_count;
    samples_next = samples_taken;
    high_next    = high_samples;
    forward_next = forward_short;
    found_next   = found_count;
    rep_valid    = 1'b0;
    rep_a        = 5'd0;
    rep_b        = 5'd0;
    done         = 1'b0;

    if ((item.action && phase == ppss_pkg::PH_IDLE) ||
        (!item.action && phase == ppss_pkg::PH_RESCAN && wait_count == 20'd0)) begin
      // Scan start.
      found_next   = 10'd0;
      first_next   = 5'd0;
      second_next  = 5'd1;
      reverse_next = 1'b0;
      forward_next = 1'b0;
      if (pin_n < 6'd2) begin
        done = 1'b1;
        if (cfg.run_continuous) begin
          phase_next = ppss_pkg::PH_RESCAN;
          wait_next  = cfg.rescan_gap_ticks;
        end else begin
          phase_next = ppss_pkg::PH_IDLE;
          wait_next  = 20'd0;
        end
      end else begin
        phase_next   = ppss_pkg::PH_SETTLE;
        wait_next    = {4'd0, cfg.settle_ticks};
        samples_next = 4'd0;
        high_next    = 4'd0;
      end
    end else if (!item.action && phase != ppss_pkg::PH_IDLE) begin
      if (wait_count != 20'd0) begin
        wait_next = wait_count - 20'd1;
      end else if (phase == ppss_pkg::PH_SETTLE ||
                   (phase == ppss_pkg::PH_GAP && samples_taken < need)) begin
        if (sense_high) begin
          high_next = high_samples + 4'd1;
        end
        samples_next = samples_taken + 4'd1;
        phase_next   = ppss_pkg::PH_GAP;
        wait_next    = {4'd0, cfg.sample_gap_ticks};
      end else if (phase == ppss_pkg::PH_GAP) begin
        if (!reverse) begin
          forward_next = shorted;
          reverse_next = 1'b1;
          phase_next   = ppss_pkg::PH_SETTLE;
          wait_next    = {4'd0, cfg.settle_ticks};
          samples_next = 4'd0;
          high_next    = 4'd0;
        end else begin
          if (forward_short || shorted) begin
            rep_valid = 1'b1;
            rep_a     = first_index;
            rep_b     = second_index;
            if (found_count != 10'h3FF) begin
              found_next = found_count + 10'd1;
            end
          end
          forward_next = 1'b0;
          reverse_next = 1'b0;
          if (last_pair) begin
            done        = 1'b1;
            first_next  = 5'd0;
            second_next = 5'd1;
            if (cfg.run_continuous) begin
              phase_next = ppss_pkg::PH_RESCAN;
              wait_next  = cfg.rescan_gap_ticks;
            end else begin
              phase_next = ppss_pkg::PH_IDLE;
              wait_next  = 20'd0;
            end
          end else begin
            first_next   = next_a[4:0];
            second_next  = next_b[4:0];
            phase_next   = ppss_pkg::PH_SETTLE;
            wait_next    = {4'd0, cfg.settle_ticks};
            samples_next = 4'd0;
            high_next    = 4'd0;
          end
        end
      end
    end
  end

  // Pin masks reflect the state after this item.
  assign driving    = (phase_next == ppss_pkg::PH_SETTLE) ||
                      (phase_next == ppss_pkg::PH_GAP);
  assign drv_idx    = reverse_next ? second_next : first_next;
  assign pd_idx     = reverse_next ? first_next : second_next;
  assign drv_onehot = {{(ppss_pkg::PIN_BITS-1){1'b0}}, 1'b1} << drv_idx;
  assign pd_onehot  = {{(ppss_pkg::PIN_BITS-1){1'b0}}, 1'b1} << pd_idx;

  always_comb begin
    result.drive_mask    = driving ? drv_onehot : '0;
    result.pulldown_mask = driving ? pd_onehot : '0;
    result.report_valid  = rep_valid;
    result.report_pin_a  = rep_a;
    result.report_pin_b  = rep_b;
    result.scan_done     = done;
    result.busy_res      = (phase_next != ppss_pkg::PH_IDLE);
    result.pairs_found   = found_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ppss_pkg::PH_IDLE;
      first_index   <= 5'd0;
      second_index  <= 5'd1;
      reverse       <= 1'b0;
      wait_count    <= 20'd0;
      samples_taken <= 4'd0;
      high_samples  <= 4'd0;
      forward_short <= 1'b0;
      found_count   <= 10'd0;
    end else if (step) begin
      phase         <= phase_next;
      first_index   <= first_next;
      second_index  <= second_next;
      reverse       <= reverse_next;
      wait_count    <= wait_next;
      samples_taken <= samples_next;
      high_samples  <= high_next;
      forward_short <= forward_next;
      found_count   <= found_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pin_pair_short_scanner_top.sv]
// Pin pair short scanner, top level. The result of an accepted item goes into
// the output register, or into the skid entry while that register is held.
// Throughput: one item per cycle; the sequencer state updates in a single pass,
// and a two-entry output buffer stalls input only when both entries hold results
// not yet taken. Reset (rst, synchronous) idles the sequencer, empties the output
// buffer and loads the register defaults. Depends on ppss_pkg and ppss_seq.
`default_nettype none

module pin_pair_short_scanner_top #(
  parameter int NUM_PINS = ppss_pkg::NUM_PINS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  ppss_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output ppss_pkg::out_item_t                  out_data,
  input  wire                                  cfg_we,
  input  wire [ppss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [ppss_pkg::CFG_DATA_W-1:0]       cfg_data
);

  ppss_pkg::cfg_t      cfg;
  ppss_pkg::out_item_t result;
  ppss_pkg::out_item_t skid_data;
  logic                skid_valid;
  logic                accept;
  logic                taken;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign taken    = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_pins      <= ppss_pkg::RST_ACTIVE_PINS;
      cfg.settle_ticks     <= ppss_pkg::RST_SETTLE_TICKS;
      cfg.confirm_count    <= ppss_pkg::RST_CONFIRM_READ;
      cfg.sample_gap_ticks <= ppss_pkg::RST_SAMPLE_GAP;
      cfg.run_continuous   <= ppss_pkg::RST_RUN_CONT;
      cfg.rescan_gap_ticks <= ppss_pkg::RST_RESCAN_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppss_pkg::REG_ACTIVE_PINS:  cfg.active_pins      <= cfg_data[4:0];
        ppss_pkg::REG_SETTLE_TICKS: cfg.settle_ticks     <= cfg_data[15:0];
        ppss_pkg::REG_CONFIRM_READ: cfg.confirm_count    <= cfg_data[3:0];
        ppss_pkg::REG_SAMPLE_GAP:   cfg.sample_gap_ticks <= cfg_data[15:0];
        ppss_pkg::REG_RUN_CONT:     cfg.run_continuous   <= cfg_data[0];
        ppss_pkg::REG_RESCAN_GAP:   cfg.rescan_gap_ticks <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  ppss_seq #(
    .NUM_PINS(NUM_PINS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // Output register plus one skid entry; the skid fills only when a new
  // item arrives while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (taken || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (out_valid && !taken && accept) begin
      skid_data <= result;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the output register is empty");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result in the next cycle");

  a_masks_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($onehot0(out_data.drive_mask) && $onehot0(out_data.pulldown_mask)
                   && ((out_data.drive_mask & out_data.pulldown_mask) == '0)))
    else $error("drive and pull-down masks overlap or are not one-hot");

  a_report_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.report_valid) |->
      (out_data.report_pin_a < out_data.report_pin_b))
    else $error("reported pair is not in ascending order");
`endif

endmodule

`default_nettype wire

[test/tb_pin_pair_short_scanner_top.sv]
// Testbench for pin_pair_short_scanner_top: directed and random tick streams, with a
// predictor of the scan sequencer and a field-by-field check of every result item.
// Depends on ppss_pkg and pin_pair_short_scanner_top.
module tb_pin_pair_short_scanner_top;
  import ppss_pkg::*;

  localparam int SCAN_PINS = NUM_PINS_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [PIN_BITS-1:0] ONE_PIN = {{(PIN_BITS-1){1'b0}}, 1'b1};
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Level patterns for the sensed pins.
  localparam int LV_HIGH   = 0;
  localparam int LV_LOW    = 1;
  localparam int LV_DENSE  = 2;
  localparam int LV_HALF   = 3;
  localparam int LV_SPARSE = 4;
  localparam int LV_MIXED  = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_item_t tick_queue[$];
  out_item_t predicted_outputs[$];
  out_item_t want;
  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;

  // Predictor copy of the registers and of the sequencer state.
  logic [4:0]  conf_pins;
  logic [15:0] conf_settle;
  logic [3:0]  conf_reads;
  logic [15:0] conf_gap;
  logic        conf_cont;
  logic [19:0] conf_rescan;
  logic [1:0]  seq_phase;
  logic [4:0]  seq_first;
  logic [4:0]  seq_second;
  logic        seq_rev;
  logic [19:0] seq_wait;
  logic [3:0]  seq_taken;
  logic [3:0]  seq_high;
  logic        seq_fwd_short;
  logic [9:0]  seq_found;

  pin_pair_short_scanner_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_predictor();
    conf_pins = RST_ACTIVE_PINS;
    conf_settle = RST_SETTLE_TICKS;
    conf_reads = RST_CONFIRM_READ;
    conf_gap = RST_SAMPLE_GAP;
    conf_cont = RST_RUN_CONT;
    conf_rescan = RST_RESCAN_GAP;
    seq_phase = PH_IDLE;
    seq_first = 5'd0;
    seq_second = 5'd1;
    seq_rev = 1'b0;
    seq_wait = '0;
    seq_taken = '0;
    seq_high = '0;
    seq_fwd_short = 1'b0;
    seq_found = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ACTIVE_PINS:  conf_pins = val[4:0];
      REG_SETTLE_TICKS: conf_settle = val[15:0];
      REG_CONFIRM_READ: conf_reads = val[3:0];
      REG_SAMPLE_GAP:   conf_gap = val[15:0];
      REG_RUN_CONT:     conf_cont = val[0];
      REG_RESCAN_GAP:   conf_rescan = val[19:0];
      default: ;
    endcase
  endfunction

  function automatic int scan_pin_count();
    return (conf_pins > SCAN_PINS) ? SCAN_PINS : int'(conf_pins);
  endfunction

  function automatic void open_direction();
    seq_phase = PH_SETTLE;
    seq_wait = {4'd0, conf_settle};
    seq_taken = '0;
    seq_high = '0;
  endfunction

  function automatic void close_scan();
    seq_first = 5'd0;
    seq_second = 5'd1;
    seq_rev = 1'b0;
    if (conf_cont) begin
      seq_phase = PH_RESCAN;
      seq_wait = conf_rescan;
    end else begin
      seq_phase = PH_IDLE;
      seq_wait = '0;
    end
  endfunction

  // Returns 1 when the scan is over at once because fewer than two pins take part.
  function automatic logic launch_scan();
    seq_found = '0;
    seq_first = 5'd0;
    seq_second = 5'd1;
    seq_rev = 1'b0;
    seq_fwd_short = 1'b0;
    if (scan_pin_count() < 2) begin
      close_scan();
      return 1'b1;
    end
    open_direction();
    return 1'b0;
  endfunction

  function automatic void take_reading(logic [PIN_BITS-1:0] levels);
    logic [4:0] sensor;
    sensor = seq_rev ? seq_first : seq_second;
    if (levels[sensor]) seq_high = seq_high + 4'd1;
    seq_taken = seq_taken + 4'd1;
    seq_phase = PH_GAP;
    seq_wait = {4'd0, conf_gap};
  endfunction

  function automatic out_item_t advance_scanner(in_item_t it);
    out_item_t r;
    logic [3:0] need;
    logic shorted;
    int n;
    int a;
    int b;
    r = '0;
    need = (conf_reads == 4'd0) ? 4'd1 : conf_reads;
    if (it.action == ACT_START) begin
      if (seq_phase == PH_IDLE) begin
        if (launch_scan()) r.scan_done = 1'b1;
      end
    end else if (seq_phase != PH_IDLE) begin
      if (seq_wait != 0) begin
        seq_wait = seq_wait - 20'd1;
      end else if (seq_phase == PH_RESCAN) begin
        if (launch_scan()) r.scan_done = 1'b1;
      end else if (seq_phase == PH_SETTLE || seq_taken < need) begin
        take_reading(it.pin_levels);
      end else begin
        shorted = (seq_high == need);
        if (!seq_rev) begin
          seq_fwd_short = shorted;
          seq_rev = 1'b1;
          open_direction();
        end else begin
          n = scan_pin_count();
          a = int'(seq_first);
          b = int'(seq_second) + 1;
          if (seq_fwd_short || shorted) begin
            r.report_valid = 1'b1;
            r.report_pin_a = seq_first;
            r.report_pin_b = seq_second;
            if (seq_found != 10'd1023) seq_found = seq_found + 10'd1;
          end
          seq_fwd_short = 1'b0;
          seq_rev = 1'b0;
          if (b >= n) begin
            a = a + 1;
            b = a + 1;
          end
          if (b >= n) begin
            close_scan();
            r.scan_done = 1'b1;
          end else begin
            seq_first = a[4:0];
            seq_second = b[4:0];
            open_direction();
          end
        end
      end
    end
    if (seq_phase == PH_SETTLE || seq_phase == PH_GAP) begin
      r.drive_mask = ONE_PIN << (seq_rev ? seq_second : seq_first);
      r.pulldown_mask = ONE_PIN << (seq_rev ? seq_first : seq_second);
    end
    r.busy_res = (seq_phase != PH_IDLE);
    r.pairs_found = seq_found;
    return r;
  endfunction

  // Checks the result item leaving the block, then predicts for the item entering it.
  always @(posedge clk) begin
    if (rst) begin
      reset_predictor();
      predicted_outputs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: result item with nothing expected, drv=%h pd=%h", $time,
                     out_data.drive_mask, out_data.pulldown_mask);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_data.drive_mask !== want.drive_mask ||
              out_data.pulldown_mask !== want.pulldown_mask ||
              out_data.report_valid !== want.report_valid ||
              out_data.report_pin_a !== want.report_pin_a ||
              out_data.report_pin_b !== want.report_pin_b ||
              out_data.scan_done !== want.scan_done ||
              out_data.busy_res !== want.busy_res ||
              out_data.pairs_found !== want.pairs_found) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: expected drv=%h pd=%h rep=%b a=%0d b=%0d done=%b busy=%b found=%0d",
                       $time, want.drive_mask, want.pulldown_mask, want.report_valid,
                       want.report_pin_a, want.report_pin_b, want.scan_done, want.busy_res,
                       want.pairs_found);
              $display("%0t: actual   drv=%h pd=%h rep=%b a=%0d b=%0d done=%b busy=%b found=%0d",
                       $time, out_data.drive_mask, out_data.pulldown_mask,
                       out_data.report_valid, out_data.report_pin_a, out_data.report_pin_b,
                       out_data.scan_done, out_data.busy_res, out_data.pairs_found);
            end
          end
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        predicted_outputs.insert(predicted_outputs.size(), advance_scanner(in_data));
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tick_queue.size() != 0) begin
        in_data <= tick_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short stall runs between longer open stretches.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(9, 0) < 4) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(7, 0);
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(29, 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [PIN_BITS-1:0] draw_levels(int bias);
    int pick;
    pick = ($urandom_range(99, 0) < 85) ? bias : LV_MIXED;
    if (pick == LV_MIXED) pick = $urandom_range(LV_SPARSE, LV_HIGH);
    case (pick)
      LV_HIGH:   return '1;
      LV_LOW:    return '0;
      LV_DENSE:  return PIN_BITS'($urandom | $urandom);
      LV_SPARSE: return PIN_BITS'($urandom & $urandom);
      default:   return PIN_BITS'($urandom);
    endcase
  endfunction

  function automatic void queue_item(logic act, logic [PIN_BITS-1:0] levels);
    in_item_t it;
    it.action = act;
    it.pin_levels = levels;
    tick_queue.insert(tick_queue.size(), it);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Ends a run of register writes and lines up with the falling edge for queueing.
  task automatic open_batch();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(negedge clk);
  endtask

  task automatic feed(input int n, input int start_pct, input int bias, input logic lead_start);
    open_batch();
    if (lead_start) queue_item(ACT_START, draw_levels(bias));
    repeat (n)
      queue_item(($urandom_range(99, 0) < start_pct) ? ACT_START : ACT_TICK, draw_levels(bias));
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: idle ticks do nothing, a start, a few settle ticks and a
    // start while busy, which is ignored.
    open_batch();
    queue_item(ACT_TICK, '0);
    queue_item(ACT_TICK, '1);
    queue_item(ACT_START, '0);
    repeat (4) queue_item(ACT_TICK, '1);
    queue_item(ACT_START, '1);
    queue_item(ACT_TICK, '0);
    wait_idle();

    // Written mid-scan: the settle count already loaded still runs down, and the
    // pair under test is finished against the new pin count.
    write_reg(REG_SETTLE_TICKS, 20'd0);
    write_reg(REG_SAMPLE_GAP, 20'd0);
    write_reg(REG_CONFIRM_READ, 20'd1);
    write_reg(REG_ACTIVE_PINS, 20'd2);
    feed(210, 0, LV_HIGH, 1'b0);

    // Fewer than two pins: the scan ends in the step that starts it.
    write_reg(REG_ACTIVE_PINS, 20'd0);
    open_batch();
    queue_item(ACT_START, '0);
    queue_item(ACT_TICK, '1);
    wait_idle();
    write_reg(REG_ACTIVE_PINS, 20'd1);
    feed(3, 0, LV_MIXED, 1'b1);

    // Zero confirm reads counts as one; upper data bits beyond the register are dropped.
    write_reg(REG_ACTIVE_PINS, 20'hFFFE3);
    write_reg(REG_CONFIRM_READ, 20'd0);
    write_reg(REG_SETTLE_TICKS, 20'd1);
    write_reg(REG_SAMPLE_GAP, 20'd1);
    feed(60, 8, LV_MIXED, 1'b1);

    // Pin count above the pin limit is clamped: one full scan of every pair.
    write_reg(REG_ACTIVE_PINS, 20'hFFFFF);
    write_reg(REG_SETTLE_TICKS, 20'd0);
    write_reg(REG_SAMPLE_GAP, 20'd0);
    write_reg(REG_CONFIRM_READ, 20'd1);
    feed(1320, 0, LV_DENSE, 1'b1);

    // Fifteen reads must all be high.
    write_reg(REG_ACTIVE_PINS, 20'd3);
    write_reg(REG_CONFIRM_READ, 20'd15);
    write_reg(REG_SETTLE_TICKS, 20'd2);
    feed(110, 5, LV_HIGH, 1'b1);

    // Continuous rescans, with registers changed while running.
    write_reg(REG_ACTIVE_PINS, 20'd4);
    write_reg(REG_SETTLE_TICKS, 20'd0);
    write_reg(REG_SAMPLE_GAP, 20'd1);
    write_reg(REG_CONFIRM_READ, 20'd2);
    write_reg(REG_RESCAN_GAP, 20'd0);
    write_reg(REG_RUN_CONT, 20'd1);
    feed(50, 5, LV_MIXED, 1'b1);
    write_reg(REG_ACTIVE_PINS, 20'd3);
    write_reg(REG_RESCAN_GAP, 20'd3);
    feed(40, 5, LV_DENSE, 1'b0);
    write_reg(REG_RESCAN_GAP, 20'hFFFFF);
    write_reg(REG_RESCAN_GAP, 20'd2);
    write_reg(REG_RUN_CONT, 20'd0);
    feed(30, 0, LV_HALF, 1'b0);

    // Random small settings, often written while a scan is under way.
    repeat (3) begin
      write_reg(REG_ACTIVE_PINS, CFG_DATA_W'($urandom_range(7, 0)));
      write_reg(REG_SETTLE_TICKS, CFG_DATA_W'($urandom_range(3, 0)));
      write_reg(REG_CONFIRM_READ, CFG_DATA_W'($urandom_range(4, 0)));
      write_reg(REG_SAMPLE_GAP, CFG_DATA_W'($urandom_range(3, 0)));
      write_reg(REG_RUN_CONT, CFG_DATA_W'($urandom_range(1, 0)));
      write_reg(REG_RESCAN_GAP, CFG_DATA_W'($urandom_range(6, 0)));
      feed($urandom_range(35, 10), 10, $urandom_range(LV_MIXED, LV_HIGH), 1'b0);
    end

    // Bring the scanner back to idle before the longest waits.
    write_reg(REG_RUN_CONT, 20'd0);
    write_reg(REG_ACTIVE_PINS, 20'd2);
    write_reg(REG_SETTLE_TICKS, 20'd0);
    write_reg(REG_SAMPLE_GAP, 20'd0);
    write_reg(REG_CONFIRM_READ, 20'd1);
    feed(60, 0, LV_MIXED, 1'b0);

    // Largest settle and sample gap on the smallest scan: the settle count runs
    // down from its top value.
    write_reg(REG_SETTLE_TICKS, 20'hFFFF);
    write_reg(REG_SAMPLE_GAP, 20'hFFFF);
    feed(40, 0, LV_MIXED, 1'b1);

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
